### rtl/olief_pkg.sv
// Shared types and constants for the ordered list insert/erase/find unit.
// Depends on nothing; every other file in rtl imports it.
package olief_pkg;

    // Default list capacity and stored word width.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes. Code seven has no meaning and is ignored.
    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_FIND       = 3'd6
    } action_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // One request word.
    typedef struct packed {
        logic [2:0]         action;
        logic [4:0]         position;
        logic signed [31:0] value;
    } req_t;

    // One result word.
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] found_index;
        logic [4:0] count_after;
    } rsp_t;

    // Edit command broadcast from the decoder to every cell.
    typedef struct packed {
        logic ins;
        logic del;
        logic find;
    } edit_t;

endpackage

### rtl/ordered_list_insert_erase_find_unit.sv
// Top level of the ordered list insert/erase/find unit: entry count,
// the row of list cells, the first-match encoder and the result register.
// Depends on olief_pkg, olief_ctrl and olief_cell.
//
//   Port group          Dir  Handshake         Contents
//   start/busy/request  in   start && !busy    action, position, value
//   done/result         out  done, one cycle   status, found, found_index, count_after
//
// Each request is decoded and applied to the cell row at the edge that
// accepts it, and its result is on the result port with done high in the
// next cycle. Shifts and key compares happen in all cells in parallel,
// so busy stays low and a request may follow every cycle.
// Reset clears the entry count and done; the cell contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_insert_erase_find_unit #(
    parameter int DEPTH      = olief_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olief_pkg::DATA_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  olief_pkg::req_t request,
    output logic            done,
    output olief_pkg::rsp_t result
);
    import olief_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  done_reg;
    rsp_t                  result_reg;
    rsp_t                  result_next;
    logic                  accept;
    edit_t                 edit_raw;
    edit_t                 edit;
    logic [CW-1:0]         tgt;
    status_t               status;
    logic [63:0]           value_wide;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic                  any_match;
    logic [IW-1:0]         first_idx;
    logic [31:0]           first_idx_wide;
    logic [31:0]           count_wide;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    // Stored words are the value field, zero-extended and cut to DATA_WIDTH.
    assign value_wide = {32'b0, request.value};
    assign wr_data    = value_wide[DATA_WIDTH-1:0];

    olief_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .req      (request),
        .cnt      (count_reg),
        .edit     (edit_raw),
        .tgt      (tgt),
        .cnt_next (count_next),
        .status   (status)
    );

    // Edits take effect only on an accepted request.
    assign edit = accept ? edit_raw : '0;

    // Row of list cells, each wired to its lower and upper neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_data;
        logic [DATA_WIDTH-1:0] upper_data;

        if (i == 0)
        begin : g_first
            assign lower_data = '0;
        end
        else
        begin : g_lower
            assign lower_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_data = '0;
        end
        else
        begin : g_upper
            assign upper_data = cell_data[i+1];
        end

        olief_cell #(
            .DW  (DATA_WIDTH),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .edit       (edit),
            .tgt        (tgt),
            .cnt        (count_reg),
            .wr_data    (wr_data),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    // Lowest matching cell wins.
    always_comb
    begin
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i])
                first_idx = IW'(i);
        end
    end

    assign any_match      = |cell_match;
    assign first_idx_wide = 32'(first_idx);
    assign count_wide     = 32'(count_next);

    // Result word for the request being accepted.
    always_comb
    begin
        result_next.status      = status;
        result_next.found       = edit_raw.find && any_match;
        result_next.found_index = (edit_raw.find && any_match) ? first_idx_wide[3:0] : 4'd0;
        result_next.count_after = count_wide[4:0];
    end

    // Entry count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/olief_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors
// and compares its entry with the search key. Depends on olief_pkg.
module olief_cell #(
    parameter int DW  = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  olief_pkg::edit_t  edit,
    input  logic [CW-1:0]     tgt,
    input  logic [CW-1:0]     cnt,
    input  logic [DW-1:0]     wr_data,
    input  logic [DW-1:0]     lower_data,
    input  logic [DW-1:0]     upper_data,
    output logic [DW-1:0]     data,
    output logic              match
);
    import olief_pkg::*;

    localparam logic [CW:0] MY_IDX = (CW+1)'(IDX);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic [CW:0]   tgt_ext;
    logic [CW:0]   cnt_ext;

    assign tgt_ext = {1'b0, tgt};
    assign cnt_ext = {1'b0, cnt};

    // Insert loads the target cell and moves the cells above it up by one;
    // erase pulls the cells from the target upward down by one.
    always_comb
    begin
        data_next = data_reg;
        if (edit.ins)
        begin
            if (MY_IDX == tgt_ext)
                data_next = wr_data;
            else if (MY_IDX > tgt_ext && MY_IDX <= cnt_ext)
                data_next = lower_data;
        end
        else if (edit.del)
        begin
            if (MY_IDX >= tgt_ext && (MY_IDX + 1'b1) < cnt_ext)
                data_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Only entries below the count take part in a search.
    assign data  = data_reg;
    assign match = (data_reg == wr_data) && (MY_IDX < cnt_ext);

endmodule

### rtl/olief_ctrl.sv
// Request decoder: checks a request against the entry count, picks the
// edit position and forms the status and the new count. Depends on olief_pkg.
module olief_ctrl #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  olief_pkg::req_t     req,
    input  logic [CW-1:0]       cnt,
    output olief_pkg::edit_t    edit,
    output logic [CW-1:0]       tgt,
    output logic [CW-1:0]       cnt_next,
    output olief_pkg::status_t  status
);
    import olief_pkg::*;

    // Wide enough for both the position field and the count.
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [PW-1:0] FULL_CNT = PW'(DEPTH);

    logic [PW-1:0] n_ext;
    logic [PW-1:0] pos;

    assign n_ext = PW'(cnt);

    // Decode the request into an edit, a status and the next count.
    always_comb
    begin
        edit     = '0;
        status   = ST_OK;
        cnt_next = cnt;
        pos      = '0;
        unique case (action_t'(req.action))
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT:
            begin
                if (action_t'(req.action) == ACT_PUSH_BACK)
                    pos = n_ext;
                else if (action_t'(req.action) == ACT_INSERT)
                    pos = PW'(req.position);
                if (pos > n_ext)
                    status = ST_BADPOS;
                else if (n_ext >= FULL_CNT)
                    status = ST_FULL;
                else
                begin
                    edit.ins = 1'b1;
                    cnt_next = cnt + 1'b1;
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE:
            begin
                if (action_t'(req.action) == ACT_POP_BACK)
                    pos = (n_ext != '0) ? n_ext - 1'b1 : '0;
                else if (action_t'(req.action) == ACT_ERASE)
                    pos = PW'(req.position);
                if (n_ext == '0)
                    status = ST_EMPTY;
                else if (pos >= n_ext)
                    status = ST_BADPOS;
                else
                begin
                    edit.del = 1'b1;
                    cnt_next = cnt - 1'b1;
                end
            end
            ACT_FIND:
            begin
                edit.find = 1'b1;
            end
            default:
            begin
                edit = '0;
            end
        endcase
    end

    // A legal edit position never exceeds the count, so it fits in CW bits.
    assign tgt = pos[CW-1:0];

endmodule

### verif/tb_ordered_list_insert_erase_find_unit.sv
// Self-checking testbench for ordered_list_insert_erase_find_unit.
// Drives directed and random list requests and checks every result word against a
// built-in list predictor. Depends on olief_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_ordered_list_insert_erase_find_unit;
    import olief_pkg::*;

    localparam int          LIST_DEPTH     = olief_pkg::DEPTH_DEF;
    localparam logic [2:0]  ACT_RESERVED   = 3'd7;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_GAP        = 30;
    localparam int          DRAIN_CYCLES   = 4;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    req_t   request = '0;
    logic   done;
    rsp_t   result;

    // List predictor state.
    logic [31:0] list_copy [LIST_DEPTH];
    int unsigned list_len = 0;

    // Result words still owed by the unit, oldest first.
    rsp_t   pending_results [$];

    int     errors = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    int     finds_hit = 0;
    int     status_tally [4] = '{default: 0};
    int     sender_idle_pct = 0;
    int     quiet_cycles = 0;

    ordered_list_insert_erase_find_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Applies one request to the predicted list and returns its result word.
    function automatic rsp_t apply_to_list_copy(input req_t word);
        rsp_t        rsp;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        rsp = '0;
        rsp.status = ST_OK;
        n = list_len;
        pos = word.position;
        case (word.action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT:
            begin
                if (word.action == ACT_PUSH_BACK)
                    pos = n;
                else if (word.action == ACT_PUSH_FRONT)
                    pos = 0;
                // The position check wins over the full check.
                if (pos > n)
                    rsp.status = ST_BADPOS;
                else if (n >= LIST_DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    for (i = n; i > pos; i--)
                        list_copy[i] = list_copy[i - 1];
                    list_copy[pos] = word.value;
                    n++;
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE:
            begin
                if (word.action == ACT_POP_BACK)
                    pos = (n > 0) ? n - 1 : 0;
                else if (word.action == ACT_POP_FRONT)
                    pos = 0;
                // An empty list reports empty whatever the position.
                if (n == 0)
                    rsp.status = ST_EMPTY;
                else if (pos >= n)
                    rsp.status = ST_BADPOS;
                else
                begin
                    for (i = pos; i + 1 < n; i++)
                        list_copy[i] = list_copy[i + 1];
                    n--;
                end
            end
            ACT_FIND:
            begin
                for (i = 0; i < n; i++)
                begin
                    if (list_copy[i] == word.value)
                    begin
                        rsp.found = 1'b1;
                        rsp.found_index = i[3:0];
                        break;
                    end
                end
            end
            default:
            begin
                // The reserved code leaves the list alone.
            end
        endcase
        list_len = n;
        rsp.count_after = n[4:0];
        return rsp;
    endfunction

    // Sends one request word, records its expected result, then idles at random.
    task automatic send_request(input req_t word);
        rsp_t owed;
        int   gap;
        start <= 1'b1;
        request <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        owed = apply_to_list_copy(word);
        pending_results.push_back(owed);
        words_sent++;
        status_tally[owed.status]++;
        if (owed.found)
            finds_hit++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap++;
        end
    endtask

    task automatic send_fields(input logic [2:0] action, input logic [4:0] position,
                               input logic [31:0] value);
        req_t word;
        word.action = action;
        word.position = position;
        word.value = value;
        send_request(word);
    endtask

    // Value that often repeats, so that finds hit and duplicates occur.
    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal requests; the grow flag tilts the mix toward filling or draining.
    function automatic req_t random_list_request(input bit grow);
        req_t        word;
        int unsigned pick;
        int unsigned n;
        n = list_len;
        pick = $urandom_range(99);
        if (pick < 2)
            word.action = ACT_RESERVED;
        else if (pick < 14)
            word.action = ACT_FIND;
        else if (pick < (grow ? 64 : 34))
        begin
            case ($urandom_range(2))
                0: word.action = ACT_PUSH_BACK;
                1: word.action = ACT_PUSH_FRONT;
                default: word.action = ACT_INSERT;
            endcase
        end
        else
        begin
            case ($urandom_range(2))
                0: word.action = ACT_POP_BACK;
                1: word.action = ACT_POP_FRONT;
                default: word.action = ACT_ERASE;
            endcase
        end
        // Positions are mostly in range, sometimes anywhere in the field.
        if ($urandom_range(9) == 0)
            word.position = 5'($urandom_range(31));
        else if (word.action == ACT_ERASE && n > 0)
            word.position = 5'($urandom_range(n - 1));
        else
            word.position = 5'($urandom_range(n));
        word.value = random_value();
        return word;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every done cycle carries one result word; compare it with the oldest owed one.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %p", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                words_checked++;
                check_field("status", want.status, result.status);
                check_field("found", want.found, result.found);
                check_field("found_index", want.found_index, result.found_index);
                check_field("count_after", want.count_after, result.count_after);
            end
        end
    end

    // The run ends if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timed out with %0d result words still owed.", pending_results.size());
            $display("[ordered_list_insert_erase_find_unit] ERROR");
            $finish;
        end
    end

    // Faults and lookups on an empty list, plus the reserved code.
    task automatic test_empty_list();
        send_fields(ACT_POP_BACK, 5'd0, 32'd0);
        send_fields(ACT_POP_FRONT, 5'd0, 32'd0);
        send_fields(ACT_ERASE, 5'd31, 32'd0);
        send_fields(ACT_FIND, 5'd0, 32'd0);
        send_fields(ACT_RESERVED, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Fill to capacity with every kind of insertion, then hit the full and range faults.
    task automatic test_fill_to_capacity();
        int i;
        send_fields(ACT_PUSH_BACK, 5'd0, 32'h8000_0000);
        send_fields(ACT_PUSH_FRONT, 5'd0, 32'hFFFF_FFFF);
        send_fields(ACT_INSERT, 5'd1, 32'h7FFF_FFFF);
        send_fields(ACT_INSERT, 5'd3, 32'd0);
        for (i = 0; i < LIST_DEPTH - 4; i++)
            send_fields((i % 2 == 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, 5'd0, 32'(i * 3 - 7));
        send_fields(ACT_PUSH_BACK, 5'd0, 32'd1);
        send_fields(ACT_INSERT, 5'd16, 32'd1);
        send_fields(ACT_INSERT, 5'd17, 32'd1);
    endtask

    // Lookups and erases on a full list.
    task automatic test_find_and_erase();
        send_fields(ACT_FIND, 5'd0, 32'h7FFF_FFFF);
        send_fields(ACT_FIND, 5'd0, 32'h1234_5678);
        send_fields(ACT_ERASE, 5'd16, 32'd0);
        send_fields(ACT_ERASE, 5'd7, 32'd0);
    endtask

    // Random requests; the fill tilt is drawn anew every 32 words.
    task automatic test_random_traffic(input int words, input int idle_pct);
        int i;
        bit grow;
        sender_idle_pct = idle_pct;
        grow = 1'b1;
        for (i = 0; i < words; i++)
        begin
            if (i % 32 == 0)
                grow = $urandom_range(1);
            send_request(random_list_request(grow));
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_fill_to_capacity();
        test_find_and_erase();
        test_random_traffic(700, 0);
        test_random_traffic(700, 57);
        test_random_traffic(600, 9);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Sent %0d requests and checked %0d result words; %0d finds hit.",
                 words_sent, words_checked, finds_hit);
        $display("Status mix: ok %0d, empty %0d, full %0d, bad position %0d.",
                 status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_FULL],
                 status_tally[ST_BADPOS]);
        if (errors == 0)
            $display("[ordered_list_insert_erase_find_unit] OK");
        else
            $display("[ordered_list_insert_erase_find_unit] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/olief_pkg.sv
rtl/olief_cell.sv
rtl/olief_ctrl.sv
rtl/ordered_list_insert_erase_find_unit.sv
verif/tb_ordered_list_insert_erase_find_unit.sv
